/* src/cabn_pkg.sv */
// Shared types and constants of the class-aware box suppression unit.
`default_nettype none
package cabn_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int COORD_W       = 16;
    localparam int SCORE_W       = 16;
    localparam int CLASS_W       = 8;
    localparam logic [SCORE_W-1:0] THR_RESET = 16'd29491;

    // One stored box: corners, score and class.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [SCORE_W-1:0]        score;
        logic [CLASS_W-1:0]        cls;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    // Status of the overlap pipeline as seen by the controller.
    typedef struct packed {
        logic busy;
        logic hit;
    } iou_stat_t;

endpackage
`default_nettype wire

/* src/class_aware_box_nms_unit.sv */
// Top level of the class-aware greedy box suppression unit.
// Boxes load at one item per cycle into a box memory until the item marked final_box.
// Suppression then takes, for each of the n stored boxes, a scan of the box
// memory to select the next box in score order, a pass of the overlap pipeline
// over the k boxes kept so far (one kept-list read per cycle), and a decision;
// each kept box is then delivered. The pace is set by the single read port of the
// box memory and of the kept-list memory. Input items are refused from the final
// item until the last result has been taken.
`default_nettype none
module class_aware_box_nms_unit #(
    parameter int MAX_BOXES = cabn_pkg::MAX_BOXES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [15:0]  left_edge,
    input  wire logic signed [15:0]  top_edge,
    input  wire logic signed [15:0]  right_edge,
    input  wire logic signed [15:0]  bottom_edge,
    input  wire logic [15:0]         confidence,
    input  wire logic [7:0]          class_id,
    input  wire logic                final_box,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [15:0]       kept_left,
    output logic signed [15:0]       kept_top,
    output logic signed [15:0]       kept_right,
    output logic signed [15:0]       kept_bottom,
    output logic [15:0]              kept_score,
    output logic [7:0]               kept_class,
    output logic                     end_of_list,
    output logic                     overflowed
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);
    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BOXES);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    localparam logic [2:0] ST_LOAD      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_CMP       = 3'd2;
    localparam logic [2:0] ST_DECIDE    = 3'd3;
    localparam logic [2:0] ST_EMIT_RD   = 3'd4;
    localparam logic [2:0] ST_EMIT_LD   = 3'd5;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             box_cnt_reg, box_cnt_next;
    logic                         ovf_reg, ovf_next;
    logic [15:0]                  thr_reg, thr_next;
    logic [CNT_W-1:0]             scan_addr_reg, scan_addr_next;
    logic                         rd_v_reg, rd_v_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         first_reg, first_next;
    logic                         found_reg, found_next;
    cabn_pkg::box_t               best_reg, best_next;
    logic [CNT_W-1:0]             best_idx_reg, best_idx_next;
    logic [15:0]                  last_score_reg, last_score_next;
    logic [CNT_W-1:0]             last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]             pcnt_reg, pcnt_next;
    logic [CNT_W-1:0]             kcnt_reg, kcnt_next;
    logic [CNT_W-1:0]             kaddr_reg, kaddr_next;
    logic                         kv_reg, kv_next;
    logic                         sup_reg, sup_next;
    logic [CNT_W-1:0]             emit_reg, emit_next;
    logic                         out_valid_reg, out_valid_next;
    cabn_pkg::box_t               out_box_reg, out_box_next;
    logic                         eol_reg, eol_next;

    cabn_pkg::box_t               in_box;
    cabn_pkg::box_t               box_rdata;
    cabn_pkg::box_t               kept_rdata;
    cabn_pkg::iou_stat_t          iou_stat;
    logic                         in_fire;
    logic                         box_we;
    logic                         box_re;
    logic                         kept_we;
    logic                         kept_re;
    logic [IDX_W-1:0]             kept_raddr;
    logic                         eligible;
    logic                         better;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;

    assign in_box.left   = left_edge;
    assign in_box.top    = top_edge;
    assign in_box.right  = right_edge;
    assign in_box.bottom = bottom_edge;
    assign in_box.score  = confidence;
    assign in_box.cls    = class_id;

    // Box memory: written while loading, scanned during selection.
    assign box_we = in_fire && (box_cnt_reg < CAP);
    assign box_re = (state_reg == ST_SCAN) && (scan_addr_reg < box_cnt_reg);

    cabn_ram #(
        .WIDTH  (cabn_pkg::BOX_W),
        .DEPTH  (MAX_BOXES),
        .ADDR_W (IDX_W)
    ) u_box_ram (
        .clk   (clk),
        .we    (box_we),
        .waddr (box_cnt_reg[IDX_W-1:0]),
        .wdata (in_box),
        .re    (box_re),
        .raddr (scan_addr_reg[IDX_W-1:0]),
        .rdata (box_rdata)
    );

    // Kept-list memory: appended on each kept box, read for overlap and delivery.
    assign kept_we    = (state_reg == ST_DECIDE) && !sup_reg;
    assign kept_re    = ((state_reg == ST_CMP) && (kaddr_reg < kcnt_reg))
                        || (state_reg == ST_EMIT_RD);
    assign kept_raddr = (state_reg == ST_EMIT_RD) ? emit_reg[IDX_W-1:0]
                                                  : kaddr_reg[IDX_W-1:0];

    cabn_ram #(
        .WIDTH  (cabn_pkg::BOX_W),
        .DEPTH  (MAX_BOXES),
        .ADDR_W (IDX_W)
    ) u_kept_ram (
        .clk   (clk),
        .we    (kept_we),
        .waddr (kcnt_reg[IDX_W-1:0]),
        .wdata (best_reg),
        .re    (kept_re),
        .raddr (kept_raddr),
        .rdata (kept_rdata)
    );

    // Overlap pipeline between the candidate and each kept box.
    cabn_iou u_iou (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (kv_reg),
        .cand      (best_reg),
        .other     (kept_rdata),
        .thr       (thr_reg),
        .stat      (iou_stat)
    );

    // Selection: the next box follows the previous one in score order, ties by arrival.
    assign eligible = first_reg || (box_rdata.score < last_score_reg)
                      || ((box_rdata.score == last_score_reg) && (rd_idx_reg > last_idx_reg));
    assign better   = !found_reg || (box_rdata.score > best_reg.score);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        box_cnt_next    = box_cnt_reg;
        ovf_next        = ovf_reg;
        thr_next        = thr_reg;
        scan_addr_next  = scan_addr_reg;
        rd_v_next       = box_re;
        rd_idx_next     = scan_addr_reg;
        first_next      = first_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        last_score_next = last_score_reg;
        last_idx_next   = last_idx_reg;
        pcnt_next       = pcnt_reg;
        kcnt_next       = kcnt_reg;
        kaddr_next      = kaddr_reg;
        kv_next         = (state_reg == ST_CMP) && (kaddr_reg < kcnt_reg);
        sup_next        = sup_reg;
        emit_next       = emit_reg;
        out_valid_next  = out_valid_reg;
        out_box_next    = out_box_reg;
        eol_next        = eol_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (box_cnt_reg < CAP)
                    begin
                        box_cnt_next = box_cnt_reg + ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (final_box)
                    begin
                        state_next     = ST_SCAN;
                        scan_addr_next = '0;
                        first_next     = 1'b1;
                        found_next     = 1'b0;
                        pcnt_next      = '0;
                        kcnt_next      = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (box_re)
                begin
                    scan_addr_next = scan_addr_reg + ONE;
                end
                if (rd_v_reg && eligible && better)
                begin
                    found_next    = 1'b1;
                    best_next     = box_rdata;
                    best_idx_next = rd_idx_reg;
                end
                if (rd_v_reg && (rd_idx_reg == box_cnt_reg - ONE))
                begin
                    state_next = ST_CMP;
                    kaddr_next = '0;
                    sup_next   = 1'b0;
                end
            end
            ST_CMP:
            begin
                if (kaddr_reg < kcnt_reg)
                begin
                    kaddr_next = kaddr_reg + ONE;
                end
                if (iou_stat.hit)
                begin
                    sup_next = 1'b1;
                end
                if ((kaddr_reg == kcnt_reg) && !kv_reg && !iou_stat.busy)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!sup_reg)
                begin
                    kcnt_next = kcnt_reg + ONE;
                end
                last_score_next = best_reg.score;
                last_idx_next   = best_idx_reg;
                first_next      = 1'b0;
                found_next      = 1'b0;
                scan_addr_next  = '0;
                if (pcnt_reg + ONE == box_cnt_reg)
                begin
                    state_next = ST_EMIT_RD;
                    emit_next  = '0;
                end
                else
                begin
                    pcnt_next  = pcnt_reg + ONE;
                    state_next = ST_SCAN;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_box_next   = kept_rdata;
                out_valid_next = 1'b1;
                eol_next       = (emit_reg == kcnt_reg - ONE);
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (eol_reg)
                    begin
                        box_cnt_next = '0;
                        ovf_next     = 1'b0;
                        kcnt_next    = '0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        emit_next  = emit_reg + ONE;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            box_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            thr_reg       <= cabn_pkg::THR_RESET;
            scan_addr_reg <= '0;
            rd_v_reg      <= 1'b0;
            first_reg     <= 1'b1;
            found_reg     <= 1'b0;
            pcnt_reg      <= '0;
            kcnt_reg      <= '0;
            kaddr_reg     <= '0;
            kv_reg        <= 1'b0;
            sup_reg       <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            eol_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_cnt_reg   <= box_cnt_next;
            ovf_reg       <= ovf_next;
            thr_reg       <= thr_next;
            scan_addr_reg <= scan_addr_next;
            rd_v_reg      <= rd_v_next;
            first_reg     <= first_next;
            found_reg     <= found_next;
            pcnt_reg      <= pcnt_next;
            kcnt_reg      <= kcnt_next;
            kaddr_reg     <= kaddr_next;
            kv_reg        <= kv_next;
            sup_reg       <= sup_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            eol_reg       <= eol_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        last_score_reg <= last_score_next;
        last_idx_reg   <= last_idx_next;
        out_box_reg    <= out_box_next;
    end

    // Result port.
    assign out_valid   = out_valid_reg;
    assign kept_left   = out_box_reg.left;
    assign kept_top    = out_box_reg.top;
    assign kept_right  = out_box_reg.right;
    assign kept_bottom = out_box_reg.bottom;
    assign kept_score  = out_box_reg.score;
    assign kept_class  = out_box_reg.cls;
    assign end_of_list = eol_reg;
    assign overflowed  = ovf_reg;

    // Checks on the sequencer.
    a_out_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_EMIT_WAIT))
        else $error("result shown outside the delivery state");

    a_kept_within_stored: assert property (@(posedge clk) disable iff (!rst_n)
        kcnt_reg <= box_cnt_reg)
        else $error("more kept boxes than stored boxes");

    a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        box_cnt_reg <= CAP)
        else $error("box count beyond capacity");

    a_candidate_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> found_reg)
        else $error("no candidate selected before the decision");

endmodule
`default_nettype wire

/* src/cabn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cabn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/cabn_iou.sv */
// Pipelined overlap test: does a kept box suppress the candidate box.
`default_nettype none
module cabn_iou (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    input  wire cabn_pkg::box_t                  cand,
    input  wire cabn_pkg::box_t                  other,
    input  wire logic [cabn_pkg::SCORE_W-1:0]    thr,
    output cabn_pkg::iou_stat_t                  stat
);

    logic signed [16:0] w_raw;
    logic signed [16:0] h_raw;
    logic        [15:0] w_cl;
    logic        [15:0] h_cl;
    logic signed [16:0] dxa;
    logic signed [16:0] dya;
    logic signed [16:0] dxb;
    logic signed [16:0] dyb;
    logic signed [15:0] min_r;
    logic signed [15:0] max_l;
    logic signed [15:0] min_b;
    logic signed [15:0] max_t;

    logic               s1_v_reg;
    logic               s1_same_reg;
    logic        [31:0] s1_inter_reg;
    logic signed [33:0] s1_area_a_reg;
    logic signed [33:0] s1_area_b_reg;

    logic signed [35:0] uni;
    logic signed [52:0] prod;

    logic               s2_v_reg;
    logic               s2_same_reg;
    logic               s2_pos_reg;
    logic        [31:0] s2_inter_reg;
    logic signed [52:0] s2_prod_reg;
    logic signed [52:0] lhs;

    // Intersection extents, clamped at zero, and the two box extents.
    always_comb
    begin
        min_r = (cand.right < other.right) ? cand.right : other.right;
        max_l = (cand.left > other.left) ? cand.left : other.left;
        min_b = (cand.bottom < other.bottom) ? cand.bottom : other.bottom;
        max_t = (cand.top > other.top) ? cand.top : other.top;
        w_raw = 17'(min_r) - 17'(max_l);
        h_raw = 17'(min_b) - 17'(max_t);
        w_cl  = w_raw[16] ? 16'd0 : w_raw[15:0];
        h_cl  = h_raw[16] ? 16'd0 : h_raw[15:0];
        dxa   = 17'(cand.right) - 17'(cand.left);
        dya   = 17'(cand.bottom) - 17'(cand.top);
        dxb   = 17'(other.right) - 17'(other.left);
        dyb   = 17'(other.bottom) - 17'(other.top);
    end

    // Valid bits of both stages, then stage one: intersection and area products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= req_valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_same_reg   <= (cand.cls == other.cls);
        s1_inter_reg  <= w_cl * h_cl;
        s1_area_a_reg <= dxa * dya;
        s1_area_b_reg <= dxb * dyb;
    end

    // Stage two: union and the threshold product.
    always_comb
    begin
        uni  = 36'(s1_area_a_reg) + 36'(s1_area_b_reg) - $signed({4'b0, s1_inter_reg});
        prod = 53'($signed({1'b0, thr})) * 53'(uni);
    end

    always_ff @(posedge clk)
    begin
        s2_same_reg  <= s1_same_reg;
        s2_pos_reg   <= (uni > 36'sd0);
        s2_inter_reg <= s1_inter_reg;
        s2_prod_reg  <= prod;
    end

    // Final compare of inter * 65536 against threshold * union.
    assign lhs      = $signed({5'b0, s2_inter_reg, 16'b0});
    assign stat.hit = s2_v_reg && s2_same_reg && s2_pos_reg && (lhs > s2_prod_reg);
    assign stat.busy = s1_v_reg || s2_v_reg;

endmodule
`default_nettype wire
